// ===== rtl/tdr_pkg.sv =====
`default_nettype none

package tdr_pkg;

    typedef enum logic [1:0] {
        OP_SET_CHECKED = 2'd0,
        OP_SET_NORM    = 2'd1,
        OP_SHIFT       = 2'd2,
        OP_DIFF        = 2'd3
    } t_opcode;

    localparam int SECONDS_PER_DAY    = 86400;
    localparam int SECONDS_PER_HOUR   = 3600;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int MAX_HOUR           = 23;
    localparam int MAX_MINUTE         = 59;
    localparam int MAX_SECOND         = 59;
    localparam int HOURS_PER_DAY      = 24;

    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int FIELD_W   = 16;
    localparam int OFFSET_W  = 32;
    localparam int DIFF_W    = 32;
    localparam int TOD_W     = 17;
    localparam int OPERAND_W = 28;
    localparam int VALUE_W   = 33;

    // 86400 = 128 * 675: keep the low 7 bits, reduce the rest by 675
    localparam int LOW_W     = 7;
    localparam int HI_W      = VALUE_W - LOW_W;
    localparam int DAY_ODD   = SECONDS_PER_DAY >> LOW_W;
    localparam int ODD_REM_W = 11;

    // smallest multiple of a day that lifts any signed 32-bit value above zero
    localparam logic [VALUE_W-1:0] DAY_BIAS = VALUE_W'(64'd86400 * 64'd24856);

    localparam int QUOT_SHIFT = 36;
    localparam int QUOT_RW    = 27;
    localparam int QUOT_W     = HI_W + QUOT_RW - QUOT_SHIFT;
    localparam logic [QUOT_RW-1:0] QUOT_RECIP =
        QUOT_RW'((64'd1 << QUOT_SHIFT) / 64'd675);

    localparam int HOUR_SHIFT = 24;
    localparam int HOUR_RW    = 13;
    localparam int HOUR_PW    = HOUR_SHIFT + HOUR_W;
    localparam logic [HOUR_RW-1:0] HOUR_RECIP =
        HOUR_RW'((64'd1 << HOUR_SHIFT) / 64'd3600);

    localparam int HREM_W    = 12;
    localparam int MIN_SHIFT = 18;
    localparam int MIN_RW    = 13;
    localparam int MIN_PW    = MIN_SHIFT + MINUTE_W;
    localparam logic [MIN_RW-1:0] MIN_RECIP =
        MIN_RW'((64'd1 << MIN_SHIFT) / 64'd60);
    localparam int MREM_W = 7;

    localparam logic signed [OPERAND_W-1:0] OPND_HOUR   = OPERAND_W'(SECONDS_PER_HOUR);
    localparam logic signed [OPERAND_W-1:0] OPND_MINUTE = OPERAND_W'(SECONDS_PER_MINUTE);

    localparam logic signed [FIELD_W-1:0] FIELD_MIN   = '0;
    localparam logic signed [FIELD_W-1:0] FIELD_HOUR  = FIELD_W'(MAX_HOUR);
    localparam logic signed [FIELD_W-1:0] FIELD_MINUTE = FIELD_W'(MAX_MINUTE);
    localparam logic signed [FIELD_W-1:0] FIELD_SECOND = FIELD_W'(MAX_SECOND);

    typedef struct packed {
        t_opcode                      op;
        logic                         set_ok;
        logic [HOUR_W-1:0]            set_h;
        logic [MINUTE_W-1:0]          set_m;
        logic [SECOND_W-1:0]          set_s;
        logic signed [OPERAND_W-1:0]  operand;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/tdr_fold.sv =====
`default_nettype none

module tdr_fold
    import tdr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [VALUE_W-1:0]   i_value,
    input  t_side                i_side,
    output logic                 o_stall,
    output logic                 o_valid,
    output logic [HOUR_W-1:0]    o_hours,
    output logic [MINUTE_W-1:0]  o_minutes,
    output logic [SECOND_W-1:0]  o_seconds,
    output t_side                o_side,
    input  logic                 i_stall
);

    logic r_vd, r_ve, r_vf, r_vg, r_vh, r_vi;
    logic w_adv_d, w_adv_e, w_adv_f, w_adv_g, w_adv_h, w_adv_i;

    logic [HI_W+QUOT_RW-1:0] n_d_prod;
    logic [HI_W-1:0]         r_d_hi;
    logic [LOW_W-1:0]        r_d_lo;
    logic [QUOT_W-1:0]       r_d_quot;
    t_side                   r_d_side;

    logic [HI_W-1:0]         n_e_prod;
    logic [HI_W-1:0]         n_e_sub;
    logic [ODD_REM_W-1:0]    n_e_rem;
    logic [ODD_REM_W-1:0]    n_e_fold;
    logic [TOD_W-1:0]        r_e_tod;
    t_side                   r_e_side;

    logic [HOUR_PW-1:0]      n_f_prod;
    logic [TOD_W-1:0]        r_f_tod;
    logic [HOUR_W-1:0]       r_f_hq;
    t_side                   r_f_side;

    logic [TOD_W-1:0]        n_g_sub;
    logic [HREM_W:0]         n_g_rem;
    logic [HOUR_W-1:0]       n_g_hours;
    logic [HREM_W-1:0]       n_g_hrem;
    logic [HOUR_W-1:0]       r_g_hours;
    logic [HREM_W-1:0]       r_g_hrem;
    t_side                   r_g_side;

    logic [MIN_PW-1:0]       n_h_prod;
    logic [HOUR_W-1:0]       r_h_hours;
    logic [HREM_W-1:0]       r_h_hrem;
    logic [MINUTE_W-1:0]     r_h_mq;
    t_side                   r_h_side;

    logic [HREM_W-1:0]       n_i_sub;
    logic [MREM_W-1:0]       n_i_rem;
    logic [MINUTE_W-1:0]     n_i_minutes;
    logic [SECOND_W-1:0]     n_i_seconds;
    logic [HOUR_W-1:0]       r_i_hours;
    logic [MINUTE_W-1:0]     r_i_minutes;
    logic [SECOND_W-1:0]     r_i_seconds;
    t_side                   r_i_side;

    assign w_adv_i = !r_vi || !i_stall;
    assign w_adv_h = !r_vh || w_adv_i;
    assign w_adv_g = !r_vg || w_adv_h;
    assign w_adv_f = !r_vf || w_adv_g;
    assign w_adv_e = !r_ve || w_adv_f;
    assign w_adv_d = !r_vd || w_adv_e;
    assign o_stall = !w_adv_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_vh <= 1'b0;
            r_vi <= 1'b0;
        end else begin
            if (w_adv_d) r_vd <= i_valid;
            if (w_adv_e) r_ve <= r_vd;
            if (w_adv_f) r_vf <= r_ve;
            if (w_adv_g) r_vg <= r_vf;
            if (w_adv_h) r_vh <= r_vg;
            if (w_adv_i) r_vi <= r_vh;
        end
    end

    // estimate the quotient by 675, low by at most one
    assign n_d_prod = {{QUOT_RW{1'b0}}, i_value[VALUE_W-1:LOW_W]}
                    * {{HI_W{1'b0}}, QUOT_RECIP};

    assign n_e_prod = HI_W'(r_d_quot) * HI_W'(DAY_ODD);
    assign n_e_sub  = r_d_hi - n_e_prod;
    assign n_e_rem  = n_e_sub[ODD_REM_W-1:0];
    assign n_e_fold = (n_e_rem >= ODD_REM_W'(DAY_ODD)) ? n_e_rem - ODD_REM_W'(DAY_ODD)
                                                       : n_e_rem;

    assign n_f_prod = HOUR_PW'(r_e_tod) * HOUR_PW'(HOUR_RECIP);

    assign n_g_sub = r_f_tod - TOD_W'(r_f_hq) * TOD_W'(SECONDS_PER_HOUR);
    assign n_g_rem = n_g_sub[HREM_W:0];

    always_comb begin
        if (n_g_rem >= (HREM_W+1)'(SECONDS_PER_HOUR)) begin
            n_g_hours = r_f_hq + HOUR_W'(1);
            n_g_hrem  = HREM_W'(n_g_rem - (HREM_W+1)'(SECONDS_PER_HOUR));
        end else begin
            n_g_hours = r_f_hq;
            n_g_hrem  = n_g_rem[HREM_W-1:0];
        end
    end

    assign n_h_prod = MIN_PW'(r_g_hrem) * MIN_PW'(MIN_RECIP);

    assign n_i_sub = r_h_hrem - HREM_W'(r_h_mq) * HREM_W'(SECONDS_PER_MINUTE);
    assign n_i_rem = n_i_sub[MREM_W-1:0];

    always_comb begin
        if (n_i_rem >= MREM_W'(SECONDS_PER_MINUTE)) begin
            n_i_minutes = r_h_mq + MINUTE_W'(1);
            n_i_seconds = SECOND_W'(n_i_rem - MREM_W'(SECONDS_PER_MINUTE));
        end else begin
            n_i_minutes = r_h_mq;
            n_i_seconds = n_i_rem[SECOND_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_d) begin
            r_d_hi   <= i_value[VALUE_W-1:LOW_W];
            r_d_lo   <= i_value[LOW_W-1:0];
            r_d_quot <= n_d_prod[HI_W+QUOT_RW-1:QUOT_SHIFT];
            r_d_side <= i_side;
        end
        if (w_adv_e) begin
            r_e_tod  <= {n_e_fold[ODD_REM_W-2:0], r_d_lo};
            r_e_side <= r_d_side;
        end
        if (w_adv_f) begin
            r_f_tod  <= r_e_tod;
            r_f_hq   <= n_f_prod[HOUR_PW-1:HOUR_SHIFT];
            r_f_side <= r_e_side;
        end
        if (w_adv_g) begin
            r_g_hours <= n_g_hours;
            r_g_hrem  <= n_g_hrem;
            r_g_side  <= r_f_side;
        end
        if (w_adv_h) begin
            r_h_hours <= r_g_hours;
            r_h_hrem  <= r_g_hrem;
            r_h_mq    <= n_h_prod[MIN_PW-1:MIN_SHIFT];
            r_h_side  <= r_g_side;
        end
        if (w_adv_i) begin
            r_i_hours   <= r_h_hours;
            r_i_minutes <= n_i_minutes;
            r_i_seconds <= n_i_seconds;
            r_i_side    <= r_h_side;
        end
    end

    assign o_valid   = r_vi;
    assign o_hours   = r_i_hours;
    assign o_minutes = r_i_minutes;
    assign o_seconds = r_i_seconds;
    assign o_side    = r_i_side;

endmodule

`default_nettype wire

// ===== rtl/time_of_day_register_core.sv =====
`default_nettype none

// Time-of-day register holding hours, minutes and seconds. Commands are a
// checked set (out-of-range fields flag o_invalid and leave the time alone),
// a normalized set, a shift by a signed number of seconds modulo one day, and
// a difference against the stored second of day. Every accepted transaction
// returns exactly one result carrying the time after the command. A new
// transaction is taken every cycle while o_stall is low; its result passes
// through a pipeline of ten register stages (input, operand build, bias,
// two for the modulo by 675, two for hours, two for minutes, store). The
// only loop through the stored time is the last stage, a mixed-radix add
// that feeds the stored time registers directly, so the rate stays at one
// transaction per cycle. Bubbles collapse, so input is still taken while a
// finished result waits on a stalled output, until every stage is full.
module time_of_day_register_core
    import tdr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_opcode,
    input  logic signed [FIELD_W-1:0]   i_hours_in,
    input  logic signed [FIELD_W-1:0]   i_minutes_in,
    input  logic signed [FIELD_W-1:0]   i_seconds_in,
    input  logic signed [OFFSET_W-1:0]  i_offset,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [HOUR_W-1:0]           o_hours_out,
    output logic [MINUTE_W-1:0]         o_minutes_out,
    output logic [SECOND_W-1:0]         o_seconds_out,
    output logic                        o_invalid,
    output logic signed [DIFF_W-1:0]    o_difference
);

    logic r_va, r_vb, r_vc;
    logic w_adv_a, w_adv_b, w_adv_c, w_adv_out;
    logic w_fold_stall;

    t_opcode                      r_a_op;
    logic signed [FIELD_W-1:0]    r_a_hours;
    logic signed [FIELD_W-1:0]    r_a_minutes;
    logic signed [FIELD_W-1:0]    r_a_seconds;
    logic signed [OFFSET_W-1:0]   r_a_offset;

    t_side                        n_b_side;
    t_side                        r_b_side;
    logic signed [OFFSET_W-1:0]   r_b_offset;

    logic signed [VALUE_W-1:0]    n_c_ext;
    logic [VALUE_W-1:0]           n_c_value;
    logic [VALUE_W-1:0]           r_c_value;
    t_side                        r_c_side;

    logic                         w_f_valid;
    logic [HOUR_W-1:0]            w_f_hours;
    logic [MINUTE_W-1:0]          w_f_minutes;
    logic [SECOND_W-1:0]          w_f_seconds;
    t_side                        w_f_side;
    logic                         w_load;

    logic [HOUR_W-1:0]            r_hour;
    logic [MINUTE_W-1:0]          r_minute;
    logic [SECOND_W-1:0]          r_second;
    logic                         r_out_valid;
    logic                         r_invalid;
    logic signed [DIFF_W-1:0]     r_difference;

    logic [HOUR_W-1:0]            n_hour;
    logic [MINUTE_W-1:0]          n_minute;
    logic [SECOND_W-1:0]          n_second;
    logic                         n_invalid;
    logic signed [DIFF_W-1:0]     n_difference;

    logic [MREM_W-1:0]            w_sec_sum;
    logic [MREM_W-1:0]            w_min_sum;
    logic [HOUR_W:0]              w_hour_sum;
    logic                         w_sec_carry;
    logic                         w_min_carry;
    logic [TOD_W-1:0]             w_stored;
    logic signed [OPERAND_W-1:0]  w_stored_s;

    assign w_adv_out = !r_out_valid || !i_stall;
    assign w_adv_c   = !r_vc || !w_fold_stall;
    assign w_adv_b   = !r_vb || w_adv_c;
    assign w_adv_a   = !r_va || w_adv_b;
    assign o_stall   = !w_adv_a;
    assign w_load    = w_f_valid && w_adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_adv_a) r_va <= i_valid;
            if (w_adv_b) r_vb <= r_va;
            if (w_adv_c) r_vc <= r_vb;
        end
    end

    always_comb begin
        n_b_side.op      = r_a_op;
        n_b_side.set_ok  = (r_a_hours   inside {[FIELD_MIN : FIELD_HOUR]})
                        && (r_a_minutes inside {[FIELD_MIN : FIELD_MINUTE]})
                        && (r_a_seconds inside {[FIELD_MIN : FIELD_SECOND]});
        n_b_side.set_h   = r_a_hours[HOUR_W-1:0];
        n_b_side.set_m   = r_a_minutes[MINUTE_W-1:0];
        n_b_side.set_s   = r_a_seconds[SECOND_W-1:0];
        n_b_side.operand = OPERAND_W'(r_a_hours) * OPND_HOUR
                         + OPERAND_W'(r_a_minutes) * OPND_MINUTE
                         + OPERAND_W'(r_a_seconds);
    end

    assign n_c_ext   = (r_b_side.op == OP_SET_NORM) ? VALUE_W'(r_b_side.operand)
                                                    : VALUE_W'(r_b_offset);
    assign n_c_value = n_c_ext + DAY_BIAS;

    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_valid) begin
            r_a_op      <= t_opcode'(i_opcode);
            r_a_hours   <= i_hours_in;
            r_a_minutes <= i_minutes_in;
            r_a_seconds <= i_seconds_in;
            r_a_offset  <= i_offset;
        end
        if (w_adv_b) begin
            r_b_side   <= n_b_side;
            r_b_offset <= r_a_offset;
        end
        if (w_adv_c) begin
            r_c_value <= n_c_value;
            r_c_side  <= r_b_side;
        end
    end

    tdr_fold u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_vc),
        .i_value   (r_c_value),
        .i_side    (r_c_side),
        .o_stall   (w_fold_stall),
        .o_valid   (w_f_valid),
        .o_hours   (w_f_hours),
        .o_minutes (w_f_minutes),
        .o_seconds (w_f_seconds),
        .o_side    (w_f_side),
        .i_stall   (!w_adv_out)
    );

    // shift: add the reduced offset digit by digit with carries
    assign w_sec_sum   = MREM_W'(r_second) + MREM_W'(w_f_seconds);
    assign w_sec_carry = w_sec_sum >= MREM_W'(SECONDS_PER_MINUTE);
    assign w_min_sum   = MREM_W'(r_minute) + MREM_W'(w_f_minutes) + MREM_W'(w_sec_carry);
    assign w_min_carry = w_min_sum >= MREM_W'(SECONDS_PER_MINUTE);
    assign w_hour_sum  = (HOUR_W+1)'(r_hour) + (HOUR_W+1)'(w_f_hours)
                       + (HOUR_W+1)'(w_min_carry);

    assign w_stored   = TOD_W'(r_hour) * TOD_W'(SECONDS_PER_HOUR)
                      + TOD_W'(r_minute) * TOD_W'(SECONDS_PER_MINUTE)
                      + TOD_W'(r_second);
    assign w_stored_s = OPERAND_W'(signed'({1'b0, w_stored}));

    always_comb begin
        n_hour       = r_hour;
        n_minute     = r_minute;
        n_second     = r_second;
        n_invalid    = 1'b0;
        n_difference = '0;
        case (w_f_side.op)
            OP_SET_CHECKED: begin
                if (w_f_side.set_ok) begin
                    n_hour   = w_f_side.set_h;
                    n_minute = w_f_side.set_m;
                    n_second = w_f_side.set_s;
                end else begin
                    n_invalid = 1'b1;
                end
            end
            OP_SET_NORM: begin
                n_hour   = w_f_hours;
                n_minute = w_f_minutes;
                n_second = w_f_seconds;
            end
            OP_SHIFT: begin
                n_second = w_sec_carry
                         ? SECOND_W'(w_sec_sum - MREM_W'(SECONDS_PER_MINUTE))
                         : SECOND_W'(w_sec_sum);
                n_minute = w_min_carry
                         ? MINUTE_W'(w_min_sum - MREM_W'(SECONDS_PER_MINUTE))
                         : MINUTE_W'(w_min_sum);
                n_hour   = (w_hour_sum >= (HOUR_W+1)'(HOURS_PER_DAY))
                         ? HOUR_W'(w_hour_sum - (HOUR_W+1)'(HOURS_PER_DAY))
                         : HOUR_W'(w_hour_sum);
            end
            OP_DIFF: begin
                n_difference = DIFF_W'(w_stored_s - w_f_side.operand);
            end
            default: begin
                n_invalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour      <= '0;
            r_minute    <= '0;
            r_second    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv_out) r_out_valid <= w_f_valid;
            if (w_load) begin
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_second <= n_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_invalid    <= n_invalid;
            r_difference <= n_difference;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hours_out   = r_hour;
    assign o_minutes_out = r_minute;
    assign o_seconds_out = r_second;
    assign o_invalid     = r_invalid;
    assign o_difference  = r_difference;

`ifndef SYNTH
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_f_valid |-> (w_f_hours <= HOUR_W'(MAX_HOUR)
                    && w_f_minutes <= MINUTE_W'(MAX_MINUTE)
                    && w_f_seconds <= SECOND_W'(MAX_SECOND)))
        else $error("reduced time of day out of range");

    a_hold_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> $stable({r_hour, r_minute, r_second}))
        else $error("stored time changed without a transaction");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_f_side.op == OP_SET_CHECKED && !w_f_side.set_ok)
        |=> ($stable({r_hour, r_minute, r_second}) && o_invalid && o_valid))
        else $error("rejected set altered the time or lost its flag");
`endif

endmodule

`default_nettype wire
